// ===== rtl/core/ipv4rxcv_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4rxcv_pkg
// Shared types, constants and ones' complement helper for the IPv4 receive
// checksum verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4rxcv_pkg;

  // Input beat: one datagram byte and its last mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Result beat: one per datagram
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [5:0]  header_bytes;
    logic [15:0] used_length;
  } out_beat_t;

  // Per-datagram accumulated fields, also the snapshot taken at the last beat
  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  ver_ihl;
    logic [15:0] claimed_total;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] header_sum;
    logic [15:0] transport_sum;
    logic [15:0] udp_csum;
  } snap_t;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_HLEN   = 3'd2;
  localparam logic [2:0] ST_HCSUM  = 3'd3;
  localparam logic [2:0] ST_TRUNC  = 3'd4;
  localparam logic [2:0] ST_TCSUM  = 3'd5;

  // Protocol numbers
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Header byte offsets
  localparam logic [15:0] IDX_VER_IHL = 16'd0;
  localparam logic [15:0] IDX_LEN_HI  = 16'd2;
  localparam logic [15:0] IDX_LEN_LO  = 16'd3;
  localparam logic [15:0] IDX_PROTO   = 16'd9;
  localparam logic [15:0] IDX_SRC     = 16'd12;
  localparam logic [15:0] IDX_DST     = 16'd16;
  localparam logic [15:0] IDX_HDR_END = 16'd20;

  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [5:0]  HDR_MIN_BYTES = 6'd20;
  localparam logic [6:0]  TCP_CSUM_OFS  = 7'd16;
  localparam logic [6:0]  UDP_CSUM_OFS  = 7'd6;
  localparam logic [15:0] CSUM_GOOD     = 16'hffff;
  localparam logic [15:0] COUNT_MAX     = 16'hffff;

  // 16-bit ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ipv4rxcv_accum.sv =====
// ----------------------------------------------------------------------------
// ipv4rxcv_accum
// Input register and per-byte accumulator: captures header fields, keeps the
// header and transport ones' complement sums, and hands a snapshot downstream
// at the last beat of each datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4rxcv_accum (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ipv4rxcv_pkg::in_beat_t in_beat_i,
  output logic                       snap_valid_o,
  input  wire logic                  snap_ready_i,
  output ipv4rxcv_pkg::snap_t        snap_o
);
  import ipv4rxcv_pkg::*;

  logic        in_valid_q;
  in_beat_t    in_q;
  snap_t       acc_q, acc_d;
  logic [7:0]  held_q, held_d;
  logic        snap_valid_q;
  snap_t       snap_q;

  logic        consume;
  logic        saturated;
  logic [15:0] idx;
  logic [7:0]  b;
  logic [7:0]  vl_n;
  logic [15:0] ct_n;
  logic [7:0]  proto_n;
  logic [15:0] ihl;
  logic [15:0] csum_hi_idx;
  logic [15:0] csum_lo_idx;
  logic        in_header;
  logic        in_transport;

  // Handshake: take the held byte when it can go somewhere
  assign consume    = in_valid_q && (!in_q.last_byte || !snap_valid_q || snap_ready_i);
  assign in_ready_o = !in_valid_q || consume;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_q       <= '0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
      in_q       <= in_beat_i;
    end
  end

  // Field capture for the current byte
  assign idx       = acc_q.byte_count;
  assign b         = in_q.data_byte;
  assign saturated = (idx == COUNT_MAX);
  assign vl_n      = (idx == IDX_VER_IHL) ? b : acc_q.ver_ihl;
  assign ct_n      = (idx == IDX_LEN_HI) ? {b, 8'd0} :
                     (idx == IDX_LEN_LO) ? (acc_q.claimed_total | {8'd0, b}) :
                     acc_q.claimed_total;
  assign proto_n   = (idx == IDX_PROTO) ? b : acc_q.proto;
  assign ihl       = {8'd0, vl_n[3:0], 2'b00};
  assign csum_hi_idx = ihl + {9'd0, UDP_CSUM_OFS};
  assign csum_lo_idx = csum_hi_idx + 16'd1;
  assign in_header    = (idx < ihl);
  assign in_transport = !in_header && ((ct_n < ihl) || (idx < ct_n));

  // Next accumulator state; hold once the count saturates
  always_comb begin
    acc_d  = acc_q;
    held_d = held_q;
    if (!saturated) begin
      acc_d.ver_ihl       = vl_n;
      acc_d.claimed_total = ct_n;
      acc_d.proto         = proto_n;
      if (idx >= IDX_SRC && idx < IDX_DST) begin
        acc_d.src_addr = {acc_q.src_addr[23:0], b};
      end
      if (idx >= IDX_DST && idx < IDX_HDR_END) begin
        acc_d.dst_addr = {acc_q.dst_addr[23:0], b};
      end
      if (in_header) begin
        if (!idx[0]) begin
          held_d = b;
        end else begin
          acc_d.header_sum = oc_add(acc_q.header_sum, {held_q, b});
        end
      end else if (in_transport) begin
        acc_d.transport_sum = oc_add(acc_q.transport_sum,
                                     idx[0] ? {8'd0, b} : {b, 8'd0});
      end
      if (proto_n == PROTO_UDP) begin
        if (idx == csum_hi_idx) acc_d.udp_csum[15:8] = b;
        if (idx == csum_lo_idx) acc_d.udp_csum[7:0]  = b;
      end
      acc_d.byte_count = idx + 16'd1;
    end
  end

  // Accumulator registers; clear after the last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else if (consume) begin
      if (in_q.last_byte) begin
        acc_q  <= '0;
        held_q <= '0;
      end else begin
        acc_q  <= acc_d;
        held_q <= held_d;
      end
    end
  end

  // Snapshot register toward the checker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      snap_q       <= '0;
    end else begin
      if (consume && in_q.last_byte) begin
        snap_valid_q <= 1'b1;
        snap_q       <= acc_d;
      end else if (snap_ready_i) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

`ifndef SYNTH
  // State starts fresh after every datagram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_q.last_byte) |=> (acc_q.byte_count == 16'd0 && acc_q.header_sum == 16'd0))
    else $error("accumulator not cleared after last beat");

  // Count advances by one per unmarked byte until it saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && !in_q.last_byte && !saturated)
      |=> (acc_q.byte_count == $past(acc_q.byte_count) + 16'd1))
    else $error("byte count did not advance");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ipv4rxcv_check.sv =====
// ----------------------------------------------------------------------------
// ipv4rxcv_check
// Final checks on a datagram snapshot: version, header length, trimming,
// header checksum and pseudo-header transport checksum; registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4rxcv_check (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                snap_valid_i,
  output logic                     snap_ready_o,
  input  wire ipv4rxcv_pkg::snap_t snap_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ipv4rxcv_pkg::out_beat_t  out_beat_o
);
  import ipv4rxcv_pkg::*;

  logic        out_valid_q;
  out_beat_t   out_q;
  out_beat_t   res;

  logic [15:0] len;
  logic [5:0]  ihl6;
  logic [15:0] ihl16;
  logic        have_hdr;
  logic        ver_ok;
  logic        hlen_ok;
  logic        trim_ok;
  logic [15:0] used;
  logic        is_tcp;
  logic        is_udp;
  logic [6:0]  csum_ofs;
  logic [15:0] need_len;
  logic [15:0] pay_len;
  logic [18:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign snap_ready_o = !out_valid_q || out_ready_i;

  // Header sanity
  assign len      = snap_i.byte_count;
  assign ihl6     = {snap_i.ver_ihl[3:0], 2'b00};
  assign ihl16    = {10'd0, ihl6};
  assign have_hdr = (len >= IDX_HDR_END);
  assign ver_ok   = (snap_i.ver_ihl[7:4] == IP_VERSION);
  assign hlen_ok  = (ihl6 >= HDR_MIN_BYTES) && (len >= ihl16);

  // Trim to the total-length field when it is in range
  assign trim_ok = (snap_i.claimed_total >= ihl16) && (snap_i.claimed_total <= len);
  assign used    = (have_hdr && ver_ok && hlen_ok && trim_ok) ? snap_i.claimed_total : len;

  // Transport checksum position and pseudo-header sum
  assign is_tcp   = (snap_i.proto == PROTO_TCP);
  assign is_udp   = (snap_i.proto == PROTO_UDP);
  assign csum_ofs = {1'b0, ihl6} + (is_tcp ? TCP_CSUM_OFS : UDP_CSUM_OFS);
  assign need_len = {9'd0, csum_ofs} + 16'd2;
  assign pay_len  = used - ihl16;
  assign total    = {3'd0, snap_i.transport_sum}
                  + {3'd0, snap_i.src_addr[31:16]} + {3'd0, snap_i.src_addr[15:0]}
                  + {3'd0, snap_i.dst_addr[31:16]} + {3'd0, snap_i.dst_addr[15:0]}
                  + {11'd0, snap_i.proto} + {3'd0, pay_len};
  assign fold1    = {1'b0, total[15:0]} + {14'd0, total[18:16]};
  assign fold2    = fold1[15:0] + {15'd0, fold1[16]};

  // Build the result beat
  always_comb begin
    res                = '0;
    res.header_bytes   = ihl6;
    res.used_length    = used;
    res.protocol       = have_hdr ? snap_i.proto : 8'd0;
    res.source_address = have_hdr ? snap_i.src_addr : 32'd0;
    res.dest_address   = have_hdr ? snap_i.dst_addr : 32'd0;
    if (!have_hdr || !ver_ok) begin
      res.status = ST_SHORT;
    end else if (!hlen_ok) begin
      res.status = ST_HLEN;
    end else if (snap_i.header_sum != CSUM_GOOD) begin
      res.status = ST_HCSUM;
    end else if (is_tcp || is_udp) begin
      if (used < need_len) begin
        res.status = ST_TRUNC;
      end else if (!(is_udp && snap_i.udp_csum == 16'd0) && fold2 != CSUM_GOOD) begin
        res.status = ST_TCSUM;
      end else begin
        res.status = ST_OK;
      end
    end else begin
      res.status = ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (snap_ready_o) begin
      out_valid_q <= snap_valid_i;
      if (snap_valid_i) begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTH
  // A passing datagram always has a full-size header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_OK) |-> (out_q.header_bytes >= HDR_MIN_BYTES))
    else $error("ok status with short header");

  // Past the length checks, the used length covers the header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_SHORT && out_q.status != ST_HLEN)
      |-> ({10'd0, out_q.header_bytes} <= out_q.used_length))
    else $error("used length below header length");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ipv4_rx_checksum_verifier_top.sv =====
// A last byte passes the input, snapshot and output registers to its result.
// One byte per cycle unless a last byte waits on a held snapshot; one result
// per datagram at its last byte; a 16-bit end-around add sets the byte rate.
// Reset (rst_ni, async, active low) clears all sums, counters and valids;
// no clearing pass is needed, the block accepts bytes right after reset.
// ----------------------------------------------------------------------------
// ipv4_rx_checksum_verifier_top
// IPv4 receive checker: header and TCP/UDP checksum verification on a byte
// stream, one status beat per datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_rx_checksum_verifier_top (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire ipv4rxcv_pkg::in_beat_t in_beat_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output ipv4rxcv_pkg::out_beat_t     out_beat_o
);
  import ipv4rxcv_pkg::*;

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  // Byte accumulator
  ipv4rxcv_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  // Final checks and result register
  ipv4rxcv_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_o   (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_ipv4_rx_checksum_verifier_top.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_rx_checksum_verifier_top
// Self-checking bench for the IPv4 receive checksum verifier. Builds IPv4
// datagrams with correct header and TCP/UDP checksums and then corrupts,
// truncates or pads some of them. Streams them a beat per byte with random
// gaps on both sides and checks each status beat against a byte-level model
// of the verifier.
// ----------------------------------------------------------------------------
module tb_ipv4_rx_checksum_verifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4rxcv_pkg::*;

  // Total-length field choices for generated datagrams
  localparam int TL_EXACT = 0;
  localparam int TL_BELOW = 1;
  localparam int TL_ABOVE = 2;

  // Protocols that only get a header check
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_RSVD = 8'd255;

  // Verdict predictor and result scoreboard
  class csum_board;
    logic [15:0] byte_cnt;
    logic [7:0]  ver_ihl_q;
    logic [15:0] total_field;
    logic [7:0]  proto_q;
    logic [31:0] src_q;
    logic [31:0] dst_q;
    logic [15:0] hdr_acc;
    logic [15:0] xport_acc;
    logic [15:0] udp_ck;
    logic [7:0]  hi_byte;
    out_beat_t   verdicts[$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      int unsigned s;
      s = a + b;
      s = (s & 32'h0000_ffff) + (s >> 16);
      return s[15:0];
    endfunction

    function void restart();
      byte_cnt    = '0;
      ver_ihl_q   = '0;
      total_field = '0;
      proto_q     = '0;
      src_q       = '0;
      dst_q       = '0;
      hdr_acc     = '0;
      xport_acc   = '0;
      udp_ck      = '0;
      hi_byte     = '0;
    endfunction

    // Fold one accepted byte into the datagram state; queue a verdict on last
    function void note_byte(in_beat_t b);
      int          idx;
      int          ihl;
      int          len;
      int          used;
      int          at;
      logic [7:0]  d;
      logic [15:0] s;
      out_beat_t   r;
      bit          have;
      d   = b.data_byte;
      idx = byte_cnt;
      // Ignore bytes once the counter has saturated
      if (idx < 65535) begin
        if (idx == 0) ver_ihl_q = d;
        if (idx == 2) total_field = {d, 8'h00};
        if (idx == 3) total_field[7:0] = d;
        if (idx == 9) proto_q = d;
        if (idx >= 12 && idx < 16) src_q = {src_q[23:0], d};
        if (idx >= 16 && idx < 20) dst_q = {dst_q[23:0], d};
        ihl = 4 * int'(ver_ihl_q[3:0]);
        if (idx < ihl) begin
          if ((idx % 2) == 0) hi_byte = d;
          else hdr_acc = ones_add(hdr_acc, {hi_byte, d});
        end else if (int'(total_field) < ihl || idx < int'(total_field)) begin
          xport_acc = ones_add(xport_acc, ((idx % 2) != 0) ? {8'h00, d} : {d, 8'h00});
        end
        if (proto_q == PROTO_UDP) begin
          if (idx == ihl + 6) udp_ck[15:8] = d;
          if (idx == ihl + 7) udp_ck[7:0] = d;
        end
        byte_cnt = byte_cnt + 16'd1;
      end
      if (!b.last_byte) return;

      // Judge the finished datagram
      len  = byte_cnt;
      ihl  = 4 * int'(ver_ihl_q[3:0]);
      used = len;
      have = (len >= 20);
      r.status = ST_OK;
      if (!have || ver_ihl_q[7:4] != IP_VERSION) begin
        r.status = ST_SHORT;
      end else if (ihl < 20 || len < ihl) begin
        r.status = ST_HLEN;
      end else begin
        if (int'(total_field) >= ihl && int'(total_field) <= len) used = total_field;
        if (hdr_acc != 16'hffff) begin
          r.status = ST_HCSUM;
        end else if (proto_q == PROTO_TCP || proto_q == PROTO_UDP) begin
          at = ihl + ((proto_q == PROTO_TCP) ? 16 : 6);
          if (used < at + 2) begin
            r.status = ST_TRUNC;
          end else if (!(proto_q == PROTO_UDP && udp_ck == 16'h0000)) begin
            // Add the pseudo-header to the transport sum
            s = xport_acc;
            s = ones_add(s, src_q[31:16]);
            s = ones_add(s, src_q[15:0]);
            s = ones_add(s, dst_q[31:16]);
            s = ones_add(s, dst_q[15:0]);
            s = ones_add(s, {8'h00, proto_q});
            s = ones_add(s, 16'(used - ihl));
            if (s != 16'hffff) r.status = ST_TCSUM;
          end
        end
      end
      r.protocol       = have ? proto_q : 8'h00;
      r.source_address = have ? src_q : 32'h0;
      r.dest_address   = have ? dst_q : 32'h0;
      r.header_bytes   = 6'(ihl);
      r.used_length    = 16'(used);
      verdicts.push_back(r);
      restart();
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    // Compare a result beat with the oldest pending verdict
    function void check_result(out_beat_t got);
      out_beat_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got status %0d len %0d",
                 $time, got.status, got.used_length);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (got.status !== want.status) mismatch("status", want.status, got.status);
      if (got.protocol !== want.protocol) mismatch("protocol", want.protocol, got.protocol);
      if (got.source_address !== want.source_address)
        mismatch("source_address", want.source_address, got.source_address);
      if (got.dest_address !== want.dest_address)
        mismatch("dest_address", want.dest_address, got.dest_address);
      if (got.header_bytes !== want.header_bytes)
        mismatch("header_bytes", want.header_bytes, got.header_bytes);
      if (got.used_length !== want.used_length)
        mismatch("used_length", want.used_length, got.used_length);
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_beat_t  in_beat_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_beat_t out_beat_o;

  csum_board  board = new();
  logic [7:0] frame[$];
  bit         steady = 1'b0;
  int         bytes_sent = 0;

  ipv4_rx_checksum_verifier_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random, except in the steady stretch
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 29);
  end

  // Watch both channels for completed beats
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_byte(in_beat_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_beat_o);
  end

  // Build a well-formed datagram with valid header and transport checksums
  function automatic void build_frame(input int ihl_w, input logic [7:0] proto,
                                      input int pay_len, input int pad_len,
                                      input int tl_mode, input bit zero_udp);
    int          hb;
    int          tot;
    int          tl;
    int          endi;
    int          ofs;
    int          i;
    logic [15:0] tl16;
    logic [15:0] s;
    hb  = 4 * ihl_w;
    tot = hb + pay_len;
    frame.delete();
    for (i = 0; i < tot + pad_len; i++) frame.push_back(8'($urandom_range(255)));
    case (tl_mode)
      TL_BELOW: tl = $urandom_range(hb - 1);
      TL_ABOVE: tl = tot + pad_len + 1 + $urandom_range(300);
      default:  tl = tot;
    endcase
    tl16 = 16'(tl);
    // Padding counts toward the transport only when the length field is ignored
    endi = (tl_mode == TL_EXACT) ? tot : tot + pad_len;
    frame[0] = {IP_VERSION, 4'(ihl_w)};
    frame[2] = tl16[15:8];
    frame[3] = tl16[7:0];
    frame[9] = proto;

    // Seal the transport checksum over payload and pseudo-header
    ofs = hb + ((proto == PROTO_TCP) ? 16 : 6);
    if ((proto == PROTO_TCP || proto == PROTO_UDP) && endi >= ofs + 2) begin
      frame[ofs]     = 8'h00;
      frame[ofs + 1] = 8'h00;
      if (!(proto == PROTO_UDP && zero_udp)) begin
        s = '0;
        for (i = hb; i < endi; i++)
          s = csum_board::ones_add(s, ((i % 2) != 0) ? {8'h00, frame[i]} : {frame[i], 8'h00});
        for (i = 12; i < 20; i += 2) s = csum_board::ones_add(s, {frame[i], frame[i + 1]});
        s = csum_board::ones_add(s, {8'h00, proto});
        s = csum_board::ones_add(s, 16'(endi - hb));
        s = ~s;
        if (s == 16'h0000 && proto == PROTO_UDP) s = 16'hffff;
        frame[ofs]     = s[15:8];
        frame[ofs + 1] = s[7:0];
      end
    end

    // Seal the header checksum
    frame[10] = 8'h00;
    frame[11] = 8'h00;
    s = '0;
    for (i = 0; i < hb; i += 2) s = csum_board::ones_add(s, {frame[i], frame[i + 1]});
    s = ~s;
    frame[10] = s[15:8];
    frame[11] = s[7:0];
  endfunction

  // Offer one byte; hold valid and payload until accepted
  task automatic send_beat(input in_beat_t b);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame.size(); i++)
      send_beat(in_beat_t'{data_byte: frame[i], last_byte: (i == frame.size() - 1)});
    bytes_sent += frame.size();
  endtask

  task automatic trim_frame(input int keep);
    while (frame.size() > keep) void'(frame.pop_back());
  endtask

  initial begin
    int         n;
    int         r;
    int         c;
    int         ihl_w;
    int         pay;
    int         pad;
    int         tm;
    int         i;
    logic [7:0] proto;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single byte, then one byte short of a header, then an all-zero header
    frame.delete();
    frame.push_back(8'hff);
    send_frame();
    build_frame(5, PROTO_UDP, 0, 0, TL_EXACT, 1'b0);
    trim_frame(19);
    send_frame();
    frame.delete();
    repeat (20) frame.push_back(8'h00);
    send_frame();

    // Wrong version
    build_frame(5, PROTO_TCP, 20, 0, TL_EXACT, 1'b0);
    frame[0] = {4'd6, frame[0][3:0]};
    send_frame();

    // Header length below the minimum, zero, and past the received bytes
    build_frame(5, PROTO_UDP, 12, 0, TL_EXACT, 1'b0);
    frame[0] = {IP_VERSION, 4'd4};
    send_frame();
    build_frame(5, PROTO_UDP, 12, 0, TL_EXACT, 1'b0);
    frame[0] = {IP_VERSION, 4'd0};
    send_frame();
    build_frame(15, PROTO_TCP, 0, 0, TL_EXACT, 1'b0);
    trim_frame(40);
    send_frame();

    // Good UDP with and without a checksum, good TCP with odd payload and full options
    build_frame(5, PROTO_UDP, 8, 0, TL_EXACT, 1'b0);
    send_frame();
    build_frame(5, PROTO_UDP, 13, 0, TL_EXACT, 1'b1);
    send_frame();
    build_frame(5, PROTO_TCP, 21, 0, TL_EXACT, 1'b0);
    send_frame();
    build_frame(15, PROTO_TCP, 33, 0, TL_EXACT, 1'b0);
    send_frame();

    // Transport too short to hold its checksum field
    build_frame(5, PROTO_TCP, 17, 0, TL_EXACT, 1'b0);
    send_frame();
    build_frame(5, PROTO_UDP, 7, 0, TL_EXACT, 1'b0);
    send_frame();

    // Other protocols: header check only
    build_frame(5, PROTO_ICMP, 10, 0, TL_EXACT, 1'b0);
    send_frame();
    build_frame(6, PROTO_RSVD, 5, 0, TL_EXACT, 1'b0);
    send_frame();

    // Bad header checksum, bad transport checksum
    build_frame(5, PROTO_TCP, 24, 0, TL_EXACT, 1'b0);
    frame[8] = frame[8] ^ 8'h01;
    send_frame();
    build_frame(5, PROTO_UDP, 16, 0, TL_EXACT, 1'b0);
    frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'h80;
    send_frame();

    // Length field below header, above received, and trimming of padding
    build_frame(5, PROTO_UDP, 20, 2, TL_BELOW, 1'b0);
    send_frame();
    build_frame(5, PROTO_TCP, 25, 3, TL_ABOVE, 1'b0);
    send_frame();
    build_frame(5, PROTO_TCP, 22, 4, TL_EXACT, 1'b0);
    send_frame();

    // Random datagrams: mostly well formed, some broken, some noise
    n = 0;
    while (bytes_sent < 950 || n < 4) begin
      steady = (n >= 1 && n < 3);
      r = $urandom_range(99);
      if (r < 8) begin
        frame.delete();
        repeat ($urandom_range(1, 70)) frame.push_back(8'($urandom_range(255)));
      end else begin
        ihl_w = ($urandom_range(99) < 70) ? 5 : $urandom_range(6, 15);
        c     = $urandom_range(99);
        proto = (c < 40) ? PROTO_TCP : (c < 80) ? PROTO_UDP : 8'($urandom_range(255));
        pay   = ($urandom_range(99) < 85) ? $urandom_range(0, 40) : $urandom_range(41, 200);
        pad   = ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 5);
        tm    = $urandom_range(99);
        build_frame(ihl_w, proto, pay, pad,
                    (tm < 80) ? TL_EXACT : (tm < 90) ? TL_BELOW : TL_ABOVE,
                    $urandom_range(99) < 15);
        c = $urandom_range(99);
        if (c < 12) begin
          i = $urandom_range(frame.size() - 1);
          frame[i] = frame[i] ^ (8'h01 << $urandom_range(7));
        end else if (c < 20) begin
          trim_frame($urandom_range(1, frame.size()));
        end else if (c < 25) begin
          frame[0] = {4'($urandom_range(15)), frame[0][3:0]};
        end else if (c < 30) begin
          frame[0] = {frame[0][7:4], 4'($urandom_range(15))};
        end
      end
      send_frame();
      n++;
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding verdicts, then let the pipeline settle
    while (board.verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #200_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ipv4rxcv_pkg.sv
rtl/core/ipv4rxcv_accum.sv
rtl/core/ipv4rxcv_check.sv
rtl/core/ipv4_rx_checksum_verifier_top.sv
bench/tb_ipv4_rx_checksum_verifier_top.sv
